FILE: hdl/tsl_pkg.sv
package tsl_pkg;

  localparam int COORD_BITS = 12;
  localparam int ID_BITS    = 16;
  localparam int IDX_BITS   = 3;

  typedef enum logic [1:0] {
    CMD_NEW         = 2'd0,
    CMD_GET         = 2'd1,
    CMD_RELEASE     = 2'd2,
    CMD_RELEASE_ALL = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_t;

  typedef struct packed {
    cmd_t                  command;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [ID_BITS-1:0]    release_id;
  } req_t;

  typedef struct packed {
    logic                  found;
    logic [IDX_BITS-1:0]   slot_index;
    logic [ID_BITS-1:0]    slot_touch_id;
    logic [COORD_BITS-1:0] slot_x;
    logic [COORD_BITS-1:0] slot_y;
  } res_t;

endpackage

FILE: hdl/touch_slot_tracker.sv
// touch slot tracker
// a request carries one command: new touch, find touch, release id or release all.
// requests come in on req/req_valid/req_ready, one result per request leaves on
// res/res_valid/res_ready.
// a request is taken only while the tracker is idle. one shared compare unit then
// visits the slots one per cycle, lowest slot first, up to all MAX_TOUCHES of them, and
// the result is then loaded into the output register.
// new touch stops at the first free slot and find touch at the first exact match,
// so those finish early when a slot low in the table answers.
// req_ready comes back when the result is loaded, so a new request is taken only
// once the tracker is through with the last one.
// the result sits in an output register, so the next request is taken while a
// finished result still waits; if the receiver stalls longer, the following result
// waits in the tracker and req_ready stays low until the output register frees.
// reset frees all slots, clears the id counter and drops res_valid.
module touch_slot_tracker
  import tsl_pkg::*;
#(
  parameter int MAX_TOUCHES = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  localparam int SLOT_W = (MAX_TOUCHES > 1) ? $clog2(MAX_TOUCHES) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_TOUCHES - 1);

  state_t state, state_next;

  logic [MAX_TOUCHES-1:0] active;
  logic [ID_BITS-1:0]     slot_id [MAX_TOUCHES];
  logic [COORD_BITS-1:0]  slot_px [MAX_TOUCHES];
  logic [COORD_BITS-1:0]  slot_py [MAX_TOUCHES];
  logic [ID_BITS-1:0]     id_counter;

  req_t                  cur;
  logic [SLOT_W-1:0]     scan;
  logic [1:0]            count;
  logic                  r_found;
  logic [IDX_BITS-1:0]   r_idx;
  logic [ID_BITS-1:0]    r_id;
  logic [COORD_BITS-1:0] r_x;
  logic [COORD_BITS-1:0] r_y;

  // shared compare unit on the slot under the scan pointer
  logic                  act;
  logic                  coord_eq;
  logic                  id_eq;
  logic                  last;
  logic                  step_done;
  logic [1:0]            count_next;
  logic                  out_free;

  always_comb begin
    act        = active[scan];
    coord_eq   = (slot_px[scan] == cur.pos_x) && (slot_py[scan] == cur.pos_y);
    id_eq      = (slot_id[scan] == cur.release_id);
    last       = (scan == LAST_SLOT);
    count_next = (act && count != 2'd2) ? count + 2'd1 : count;
    out_free   = !res_valid || res_ready;
    unique case (cur.command)
      CMD_NEW:         step_done = !act || last;
      CMD_GET:         step_done = (act && coord_eq) || last;
      CMD_RELEASE:     step_done = last;
      CMD_RELEASE_ALL: step_done = last;
      default:         step_done = last;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (step_done) state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= '0;
      id_counter <= '0;
      res_valid  <= 1'b0;
    end else begin
      // in hold the result load below decides res_valid
      if (res_valid && res_ready && state != ST_HOLD) res_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            cur     <= req;
            scan    <= '0;
            count   <= 2'd0;
            r_found <= 1'b0;
            r_idx   <= '0;
            r_id    <= '0;
            r_x     <= '0;
            r_y     <= '0;
          end
        end
        ST_SCAN: begin
          scan <= scan + SLOT_W'(1);
          unique case (cur.command)
            CMD_NEW: begin
              if (!act) begin
                active[scan]  <= 1'b1;
                slot_id[scan] <= id_counter;
                slot_px[scan] <= cur.pos_x;
                slot_py[scan] <= cur.pos_y;
                id_counter    <= id_counter + ID_BITS'(1);
                r_found       <= 1'b1;
                r_idx         <= IDX_BITS'(scan);
                r_id          <= id_counter;
                r_x           <= cur.pos_x;
                r_y           <= cur.pos_y;
              end
            end
            CMD_GET: begin
              count <= count_next;
              // an exact match wins; otherwise keep the first active slot in case
              // it turns out to be the only one
              if ((act && coord_eq) || (act && count == 2'd0)) begin
                r_idx <= IDX_BITS'(scan);
                r_id  <= slot_id[scan];
                r_x   <= slot_px[scan];
                r_y   <= slot_py[scan];
              end
              if (act && coord_eq) begin
                r_found <= 1'b1;
              end else if (last) begin
                r_found <= (count_next == 2'd1);
              end
            end
            CMD_RELEASE: begin
              if (act && id_eq) begin
                active[scan] <= 1'b0;
                r_found      <= 1'b1;
              end
            end
            CMD_RELEASE_ALL: begin
              if (act) begin
                active[scan] <= 1'b0;
                r_found      <= 1'b1;
              end
            end
            default: ;
          endcase
        end
        ST_HOLD: begin
          if (out_free) begin
            res_valid         <= 1'b1;
            res.found         <= r_found;
            res.slot_index    <= r_found ? r_idx : '0;
            res.slot_touch_id <= r_found ? r_id : '0;
            res.slot_x        <= r_found ? r_x : '0;
            res.slot_y        <= r_found ? r_y : '0;
          end
        end
        default: ;
      endcase
    end
  end

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> scan <= LAST_SLOT)
    else $error("scan pointer past last slot");

  a_res_after_hold: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == ST_HOLD)
    else $error("result raised outside hold state");

  a_id_advance: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && id_counter != $past(id_counter)
      |-> $past(state) == ST_SCAN && $past(cur.command) == CMD_NEW && !$past(act))
    else $error("id counter moved without an allocation");

  a_release_all_empty: assert property (@(posedge clk) disable iff (rst)
    state == ST_HOLD && cur.command == CMD_RELEASE_ALL |-> active == '0)
    else $error("slots still active after release all");

endmodule
